### src/sbpd_pkg.sv
`default_nettype none

package sbpd_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  localparam logic [7:0] HDR_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    ST_HDR1,
    ST_HDR2,
    ST_ID,
    ST_LEN,
    ST_DATA,
    ST_EMIT
  } parse_state_e;

endpackage

`default_nettype wire

### src/servo_bus_packet_deframer_core.sv
// one received byte is taken per cycle while a frame is being parsed
// a good frame of n stored bytes is read back from the payload ram at one byte per cycle
// while the output takes results: the input stalls while those bytes are read, longer while
// the output is held. the first result follows the last byte of the frame through the emit
// state, the ram read and the output stage, then one result per cycle while results are taken
// reset clears the parser state and the output stage; the payload ram is not cleared
`default_nettype none

module servo_bus_packet_deframer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] frame_id_o,
  output logic      [7:0] frame_length_o,
  output logic      [5:0] byte_index_o,
  output logic      [7:0] payload_byte_o,
  output logic            last_o
);

  import sbpd_pkg::*;

  parse_state_e state_q, state_d;

  logic [7:0]        held_id_q, held_id_d;
  logic [7:0]        held_len_q, held_len_d;
  logic [7:0]        seen_q, seen_d;
  logic [7:0]        sum_q, sum_d;
  logic [BUF_AW-1:0] last_idx_q, last_idx_d;
  logic [BUF_AW-1:0] rd_idx_q, rd_idx_d;

  logic              rd_pend_q;
  logic [BUF_AW-1:0] pend_idx_q;
  logic              pend_last_q;
  logic [7:0]        pend_id_q, pend_len_q;

  logic              out_valid_q;
  logic [7:0]        out_id_q, out_len_q, out_byte_q;
  logic [5:0]        out_idx_q;
  logic              out_last_q;

  logic              in_acc;
  logic              load_out;
  logic              issue;
  logic              ram_we;
  logic [7:0]        ram_rdata;
  logic [7:0]        seen_inc;
  logic [7:0]        sum_inc;

  assign in_ready_o = (state_q != ST_EMIT);
  assign in_acc     = in_valid_i && in_ready_o;

  assign load_out = rd_pend_q && (!out_valid_q || out_ready_i);
  assign issue    = (state_q == ST_EMIT) && (!rd_pend_q || load_out);

  assign ram_we   = in_acc && (state_q == ST_DATA) && (seen_q < 8'(BUF_DEPTH));
  assign seen_inc = (seen_q == 8'hFF) ? seen_q : seen_q + 8'd1;
  assign sum_inc  = sum_q + rx_byte_i;

  always_comb begin
    state_d    = state_q;
    held_id_d  = held_id_q;
    held_len_d = held_len_q;
    seen_d     = seen_q;
    sum_d      = sum_q;
    last_idx_d = last_idx_q;
    rd_idx_d   = rd_idx_q;
    unique case (state_q)
      ST_HDR1: begin
        if (in_acc && rx_byte_i == HDR_BYTE) state_d = ST_HDR2;
      end
      ST_HDR2: begin
        if (in_acc) state_d = (rx_byte_i == HDR_BYTE) ? ST_ID : ST_HDR1;
      end
      ST_ID: begin
        if (in_acc) begin
          held_id_d = rx_byte_i;
          sum_d     = rx_byte_i;
          state_d   = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_acc) begin
          held_len_d = rx_byte_i;
          seen_d     = '0;
          sum_d      = sum_inc;
          state_d    = ST_DATA;
        end
      end
      ST_DATA: begin
        if (in_acc) begin
          sum_d  = sum_inc;
          seen_d = seen_inc;
          if (seen_inc >= held_len_q) begin
            // good frame: final count below depth, so the old count is the last index
            if (sum_inc == HDR_BYTE && seen_inc < 8'(BUF_DEPTH)) begin
              last_idx_d = seen_q[BUF_AW-1:0];
              rd_idx_d   = '0;
              state_d    = ST_EMIT;
            end else begin
              state_d = ST_HDR1;
            end
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + BUF_AW'(1);
          if (rd_idx_q == last_idx_q) state_d = ST_HDR1;
        end
      end
      default: state_d = ST_HDR1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_HDR1;
      held_id_q  <= '0;
      held_len_q <= '0;
      seen_q     <= '0;
      sum_q      <= '0;
      last_idx_q <= '0;
      rd_idx_q   <= '0;
    end else begin
      state_q    <= state_d;
      held_id_q  <= held_id_d;
      held_len_q <= held_len_d;
      seen_q     <= seen_d;
      sum_q      <= sum_d;
      last_idx_q <= last_idx_d;
      rd_idx_q   <= rd_idx_d;
    end
  end

  sbpd_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(seen_q[BUF_AW-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (issue),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  // one read in flight; its data waits in the ram output until the output stage frees
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else if (issue) begin
      rd_pend_q <= 1'b1;
    end else if (load_out) begin
      rd_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_idx_q  <= rd_idx_q;
      pend_last_q <= (rd_idx_q == last_idx_q);
      pend_id_q   <= held_id_q;
      pend_len_q  <= held_len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_id_q   <= pend_id_q;
      out_len_q  <= pend_len_q;
      out_idx_q  <= 6'(pend_idx_q);
      out_byte_q <= ram_rdata;
      out_last_q <= pend_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_id_o     = out_id_q;
  assign frame_length_o = out_len_q;
  assign byte_index_o   = out_idx_q;
  assign payload_byte_o = out_byte_q;
  assign last_o         = out_last_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && issue))
    else $error("payload ram written and read in the same cycle");

  a_pend_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q && out_valid_q && !out_ready_i |=> rd_pend_q && $stable(ram_rdata))
    else $error("pending read data lost while output stalled");

  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && (rd_idx_q == last_idx_q) |=> state_q == ST_HDR1 && rd_pend_q)
    else $error("frame read-back did not end on the last index");

endmodule

`default_nettype wire

### src/sbpd_ram.sv
`default_nettype none

module sbpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sbpd_pkg::*;

  localparam int LONG_HOLD     = 240;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [7:0] fid;
    logic [7:0] flen;
    logic [5:0] idx;
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] frame_id_o;
  logic [7:0] frame_length_o;
  logic [5:0] byte_index_o;
  logic [7:0] payload_byte_o;
  logic       last_o;

  servo_bus_packet_deframer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_id_o     (frame_id_o),
    .frame_length_o (frame_length_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // bytes waiting to go out, and frame bytes still owed by the block
  logic [7:0]  rx_stream[$];
  frame_beat_t frame_beats_due[$];
  int unsigned bytes_queued = 0;
  int unsigned err_count    = 0;

  // deframer state as the predictor sees it
  parse_state_e rx_phase  = ST_HDR1;
  logic [7:0]   held_fid  = 8'h00;
  logic [7:0]   held_flen = 8'h00;
  logic [7:0]   seen_cnt  = 8'h00;
  logic [7:0]   run_sum   = 8'h00;
  logic [7:0]   frame_copy[BUF_DEPTH];

  int unsigned in_idle_pct   = 0;
  int unsigned out_idle_pct  = 0;
  int unsigned in_gap_left   = 0;
  int unsigned out_gap_left  = 0;
  int unsigned hold_left     = 0;
  bit          long_hold_req = 1'b0;
  logic        in_fire       = 1'b0;
  int unsigned idle_cycles   = 0;
  frame_beat_t beat_want;

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic int unsigned draw_gap(input int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic deframe_byte(input logic [7:0] c);
    frame_beat_t beat;
    case (rx_phase)
      ST_HDR2: rx_phase = (c == HDR_BYTE) ? ST_ID : ST_HDR1;
      ST_ID: begin
        held_fid = c;
        run_sum  = c;
        rx_phase = ST_LEN;
      end
      ST_LEN: begin
        held_flen = c;
        seen_cnt  = 8'h00;
        run_sum   = run_sum + c;
        rx_phase  = ST_DATA;
      end
      ST_DATA: begin
        // bytes past the buffer still count and still enter the sum
        if (seen_cnt < BUF_DEPTH) frame_copy[seen_cnt] = c;
        run_sum = run_sum + c;
        if (seen_cnt != 8'hFF) seen_cnt = seen_cnt + 8'd1;
        if (seen_cnt >= held_flen) begin
          if (run_sum == HDR_BYTE && seen_cnt < BUF_DEPTH) begin
            for (int k = 0; k < seen_cnt; k++) begin
              beat.fid  = held_fid;
              beat.flen = held_flen;
              beat.idx  = 6'(k);
              beat.data = frame_copy[k];
              beat.last = (k == seen_cnt - 1);
              frame_beats_due.push_back(beat);
            end
          end
          rx_phase = ST_HDR1;
        end
      end
      default: rx_phase = (c == HDR_BYTE) ? ST_HDR2 : ST_HDR1;
    endcase
  endtask

  task automatic push_rx(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  // a zero length still carries one byte, the checksum
  task automatic queue_frame(input logic [7:0] fid, input logic [7:0] flen,
                             input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    n = (flen == 8'h00) ? 1 : int'(flen);
    push_rx(HDR_BYTE);
    push_rx(HDR_BYTE);
    push_rx(fid);
    push_rx(flen);
    sum = fid + flen;
    for (int k = 0; k < n - 1; k++) begin
      b = 8'($urandom);
      push_rx(b);
      sum = sum + b;
    end
    b = HDR_BYTE - sum;
    if (!good_sum) b = b + 8'($urandom_range(1, 255));
    push_rx(b);
  endtask

  task automatic queue_random_traffic(input int unsigned n_bytes);
    int unsigned goal;
    int unsigned pick;
    int unsigned n;
    goal = bytes_queued + n_bytes;
    while (bytes_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 31) : $urandom_range(0, 8);
        queue_frame(8'($urandom), 8'(n), 1'b1);
      end else if (pick < 72) begin
        queue_frame(8'($urandom), 8'($urandom_range(0, 10)), 1'b0);
      end else if (pick < 78) begin
        queue_frame(8'($urandom), 8'($urandom_range(32, 40)), 1'b1);
      end else if (pick < 86) begin
        push_rx(HDR_BYTE);
        push_rx(8'($urandom_range(0, 254)));
      end else if (pick < 93) begin
        n = $urandom_range(1, 4);
        repeat (n) push_rx(8'($urandom));
      end else begin
        // frame cut short, the next header gets swallowed as payload
        push_rx(HDR_BYTE);
        push_rx(HDR_BYTE);
        push_rx(8'($urandom));
        push_rx(8'($urandom_range(4, 12)));
        n = $urandom_range(0, 2);
        repeat (n) push_rx(8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (rx_stream.size() != 0 || in_valid_i || frame_beats_due.size() != 0)
      @(posedge clk_i);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_gap_left != 0) begin
        in_gap_left = in_gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (rx_stream.size() != 0) begin
        rx_byte_i   <= rx_stream.pop_front();
        in_valid_i  <= 1'b1;
        in_gap_left = draw_gap(in_idle_pct);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (out_gap_left != 0) begin
        out_gap_left = out_gap_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i  <= 1'b1;
        out_gap_left = draw_gap(out_idle_pct);
      end
    end
  end

  // monitor: predict on every accepted byte, check every accepted result
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) deframe_byte(rx_byte_i);
      if (out_valid_o && out_ready_i) begin
        if (frame_beats_due.size() == 0) begin
          report_error($sformatf("unexpected result id %02h idx %0d byte %02h",
                                 frame_id_o, byte_index_o, payload_byte_o));
        end else begin
          beat_want = frame_beats_due.pop_front();
          if (frame_id_o !== beat_want.fid)
            report_error($sformatf("frame_id %02h, want %02h", frame_id_o, beat_want.fid));
          if (frame_length_o !== beat_want.flen)
            report_error($sformatf("frame_length %02h, want %02h",
                                   frame_length_o, beat_want.flen));
          if (byte_index_o !== beat_want.idx)
            report_error($sformatf("byte_index %0d, want %0d", byte_index_o, beat_want.idx));
          if (payload_byte_o !== beat_want.data)
            report_error($sformatf("payload_byte %02h, want %02h at idx %0d",
                                   payload_byte_o, beat_want.data, beat_want.idx));
          if (last_o !== beat_want.last)
            report_error($sformatf("last %b, want %b at idx %0d",
                                   last_o, beat_want.last, beat_want.idx));
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    out_ready_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames
    in_idle_pct  = 20;
    out_idle_pct = 20;
    queue_frame(8'h01, 8'd4, 1'b1);
    queue_frame(8'hFF, 8'd2, 1'b1);        // id equal to the header byte
    queue_frame(8'h00, 8'd0, 1'b1);        // zero length, checksum only
    queue_frame(8'h35, 8'd0, 1'b1);
    queue_frame(8'hA5, 8'd1, 1'b1);
    push_rx(HDR_BYTE);                     // broken header, 0x12 must send the parser back to the hunt
    push_rx(8'h12);
    queue_frame(8'h7E, 8'd3, 1'b1);
    push_rx(HDR_BYTE);
    push_rx(8'h00);
    queue_frame(8'h42, 8'd31, 1'b1);       // largest frame that fits
    queue_frame(8'h43, 8'd32, 1'b1);       // just too big, dropped
    queue_frame(8'h10, 8'd3, 1'b0);        // bad checksum, dropped
    queue_frame(8'hFF, 8'd40, 1'b1);       // well past the buffer, dropped
    queue_frame(8'h80, 8'd5, 1'b1);
    wait_drained();

    // back to back, no idling on either side
    in_idle_pct  = 0;
    out_idle_pct = 0;
    queue_random_traffic(40);
    wait_drained();

    // receiver holds off while frames keep coming
    long_hold_req = 1'b1;
    repeat (5) queue_frame(8'($urandom), 8'($urandom_range(8, 20)), 1'b1);
    wait_drained();

    in_idle_pct  = 30;
    out_idle_pct = 30;
    queue_random_traffic(40);
    wait_drained();

    in_idle_pct  = 60;
    out_idle_pct = 70;
    queue_random_traffic(25);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (frame_beats_due.size() != 0)
      report_error($sformatf("%0d results never arrived", frame_beats_due.size()));
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
